// ----- hdl/mcg_pkg.sv -----
`default_nettype none

package mcg_pkg;

    localparam logic [3:0] OP_TICK     = 4'd0;
    localparam logic [3:0] OP_START    = 4'd1;
    localparam logic [3:0] OP_STOP     = 4'd2;
    localparam logic [3:0] OP_CONTINUE = 4'd3;
    localparam logic [3:0] OP_TEMPO    = 4'd4;
    localparam logic [3:0] OP_ARM      = 4'd5;
    localparam logic [3:0] OP_CLK_ON   = 4'd6;
    localparam logic [3:0] OP_CLK_OFF  = 4'd7;
    localparam logic [3:0] OP_SYNC     = 4'd8;

    localparam logic [2:0] KIND_CLOCK    = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_STOP     = 3'd2;
    localparam logic [2:0] KIND_CONTINUE = 3'd3;
    localparam logic [2:0] KIND_POSITION = 3'd4;
    localparam logic [2:0] KIND_SIGNAL   = 3'd5;

    localparam logic CFG_CLOCKS_PER_BEAT = 1'b0;
    localparam logic CFG_TICK_ENABLE     = 1'b1;

    localparam logic [31:0] ONE_MS = 32'h0001_0000;

    typedef struct packed {
        logic [3:0]  op;
        logic        flag;
        logic [13:0] song_position;
        logic [31:0] user_period;
        logic [31:0] midi_period;
        logic [30:0] signal_at;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        to_port;
        logic [13:0] position;
        logic [30:0] user_clock;
        logic [30:0] beat;
        logic        late;
        logic        last;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_START_CLK, ST_STOP, ST_POS, ST_CONT, ST_CONT_CLK,
        ST_MIDI_ADD, ST_MIDI_HIT, ST_MIDI_CUT, ST_USER_ADD, ST_USER_HIT,
        ST_USER_CUT, ST_SIGNAL, ST_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        DC_NONE, DC_APPLY, DC_TICK, DC_EMIT_START, DC_EMIT_CLOCK, DC_EMIT_STOP,
        DC_EMIT_POS, DC_EMIT_CONT, DC_MIDI_ADD, DC_MIDI_HIT, DC_CUT_MIDI,
        DC_MIDI_DONE, DC_USER_ADD, DC_USER_HIT, DC_CUT_USER, DC_SIGNAL
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
        logic    flush;
    } ctrl_t;

    typedef struct packed {
        logic pend_start;
        logic pend_stop;
        logic pend_cont;
        logic midi_hit;
        logic midi_ge;
        logic user_hit;
        logic user_ge;
        logic sending;
        logic tick_en;
        logic emit_ok;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/mcg_ctrl.sv -----
`default_nettype none

module mcg_ctrl
    import mcg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    is_tick,
    input  wire status_t st,
    output logic         in_stall,
    output ctrl_t        ctl
);

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && is_tick && st.tick_en)
                    state_next = st.pend_start ? ST_START :
                                 st.pend_stop  ? ST_STOP  :
                                 st.pend_cont  ? ST_POS   : ST_MIDI_ADD;
            ST_START:
                if (st.emit_ok)
                    state_next = ST_START_CLK;
            ST_START_CLK:
                if (st.emit_ok)
                    state_next = st.pend_stop ? ST_STOP :
                                 st.pend_cont ? ST_POS  : ST_MIDI_ADD;
            ST_STOP:
                if (st.emit_ok)
                    state_next = st.pend_cont ? ST_POS : ST_MIDI_ADD;
            ST_POS:
                if (st.emit_ok)
                    state_next = ST_CONT;
            ST_CONT:
                if (st.emit_ok)
                    state_next = ST_CONT_CLK;
            ST_CONT_CLK:
                if (st.emit_ok)
                    state_next = ST_MIDI_ADD;
            ST_MIDI_ADD:
                state_next = ST_MIDI_HIT;
            ST_MIDI_HIT:
                if (!st.midi_hit)
                    state_next = ST_USER_ADD;
                else if (!st.sending || st.emit_ok)
                    state_next = ST_MIDI_CUT;
            ST_MIDI_CUT:
                if (!st.midi_ge)
                    state_next = ST_USER_ADD;
            ST_USER_ADD:
                state_next = ST_USER_HIT;
            ST_USER_HIT:
                state_next = st.user_hit ? ST_USER_CUT : ST_SIGNAL;
            ST_USER_CUT:
                if (!st.user_ge)
                    state_next = ST_SIGNAL;
            ST_SIGNAL:
                if (st.emit_ok)
                    state_next = ST_FLUSH;
            ST_FLUSH:
                if (st.emit_ok)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.cmd   = DC_NONE;
        ctl.flush = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    ctl.cmd = (is_tick && st.tick_en) ? DC_TICK : DC_APPLY;
            ST_START:
                if (st.emit_ok)
                    ctl.cmd = DC_EMIT_START;
            ST_START_CLK, ST_CONT_CLK:
                if (st.emit_ok)
                    ctl.cmd = DC_EMIT_CLOCK;
            ST_STOP:
                if (st.emit_ok)
                    ctl.cmd = DC_EMIT_STOP;
            ST_POS:
                if (st.emit_ok)
                    ctl.cmd = DC_EMIT_POS;
            ST_CONT:
                if (st.emit_ok)
                    ctl.cmd = DC_EMIT_CONT;
            ST_MIDI_ADD:
                ctl.cmd = DC_MIDI_ADD;
            ST_MIDI_HIT:
                if (st.midi_hit && (!st.sending || st.emit_ok))
                    ctl.cmd = DC_MIDI_HIT;
            ST_MIDI_CUT:
                ctl.cmd = st.midi_ge ? DC_CUT_MIDI : DC_MIDI_DONE;
            ST_USER_ADD:
                ctl.cmd = DC_USER_ADD;
            ST_USER_HIT:
                if (st.user_hit)
                    ctl.cmd = DC_USER_HIT;
            ST_USER_CUT:
                if (st.user_ge)
                    ctl.cmd = DC_CUT_USER;
            ST_SIGNAL:
                if (st.emit_ok)
                    ctl.cmd = DC_SIGNAL;
            ST_FLUSH:
                ctl.flush = st.emit_ok;
            default:
                ctl.cmd = DC_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/mcg_dp.sv -----
`default_nettype none

module mcg_dp
    import mcg_pkg::*;
#(
    parameter int MAX_CORRECTIONS = 100
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_t      ctl,
    input  wire in_t        in_data,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [9:0] cfg_data,
    input  wire logic       out_stall,
    output logic            out_valid,
    output out_t            out_data,
    output status_t         st
);

    localparam int CW = $clog2(MAX_CORRECTIONS + 1);
    localparam logic [CW-1:0] CUT_MAX = CW'(MAX_CORRECTIONS);

    logic        pstart_reg, pstart_next, pstop_reg, pstop_next;
    logic        pcont_reg, pcont_next, ppos_reg, ppos_next;
    logic [13:0] held_pos_reg, held_pos_next;
    logic        rtick_reg, rtick_next, sending_reg, sending_next;
    logic        started_reg, started_next, sync_reg, sync_next;
    logic [31:0] macc_reg, macc_next, uacc_reg, uacc_next;
    logic [31:0] mw_reg, mw_next, uw_reg, uw_next;
    logic [31:0] nmw_reg, nmw_next, nuw_reg, nuw_next;
    logic        tempo_reg, tempo_next;
    logic [31:0] mcnt_reg, mcnt_next, millis_reg, millis_next;
    logic [30:0] ccnt_reg, ccnt_next, beat_reg, beat_next;
    logic [9:0]  phase_reg, phase_next, phase_inc;
    logic [30:0] target_reg, target_next;
    logic [15:0] late_cnt_reg, late_cnt_next;
    logic        restarted_reg, restarted_next;
    logic        mhit_reg, mhit_next, uhit_reg, uhit_next;
    logic [CW-1:0] cut_reg, cut_next;
    out_t        stg_reg, stg_next, out_reg, out_next;
    logic        stg_valid_reg, stg_valid_next, out_valid_reg, out_valid_next;
    logic [9:0]  cpb_reg, cpb_next;
    logic        tick_en_reg, tick_en_next;

    logic        out_free, emit_en, emit_port, emit_late, do_apply;
    logic [2:0]  emit_kind;
    logic [13:0] emit_pos;
    logic [32:0] msum, usum;
    logic [31:0] madd, uadd;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign msum      = {1'b0, macc_reg} + {1'b0, ONE_MS};
    assign usum      = {1'b0, uacc_reg} + {1'b0, ONE_MS};
    assign madd      = msum[32] ? '1 : msum[31:0];
    assign uadd      = usum[32] ? '1 : usum[31:0];
    assign phase_inc = phase_reg + 10'd1;

    assign st.pend_start = pstart_reg;
    assign st.pend_stop  = pstop_reg;
    assign st.pend_cont  = pcont_reg;
    assign st.midi_hit   = mhit_reg;
    assign st.midi_ge    = macc_reg >= mw_reg;
    assign st.user_hit   = uhit_reg;
    assign st.user_ge    = uacc_reg >= uw_reg;
    assign st.sending    = sending_reg;
    assign st.tick_en    = tick_en_reg;
    assign st.emit_ok    = !stg_valid_reg || out_free;

    always_comb
    begin
        pstart_next = pstart_reg;   pstop_next = pstop_reg;
        pcont_next = pcont_reg;     ppos_next = ppos_reg;
        held_pos_next = held_pos_reg;
        rtick_next = rtick_reg;     sending_next = sending_reg;
        started_next = started_reg; sync_next = sync_reg;
        macc_next = macc_reg;       uacc_next = uacc_reg;
        mw_next = mw_reg;           uw_next = uw_reg;
        nmw_next = nmw_reg;         nuw_next = nuw_reg;
        tempo_next = tempo_reg;
        mcnt_next = mcnt_reg;       millis_next = millis_reg;
        ccnt_next = ccnt_reg;       beat_next = beat_reg;
        phase_next = phase_reg;     target_next = target_reg;
        late_cnt_next = late_cnt_reg;
        restarted_next = restarted_reg;
        mhit_next = mhit_reg;       uhit_next = uhit_reg;
        cut_next = cut_reg;
        cpb_next = cpb_reg;         tick_en_next = tick_en_reg;
        emit_en = 1'b0;  emit_kind = KIND_CLOCK;  emit_port = sync_reg;
        emit_pos = '0;   emit_late = 1'b0;  do_apply = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == CFG_CLOCKS_PER_BEAT)
                cpb_next = cfg_data;
            else
                tick_en_next = cfg_data[0];
        end

        case (ctl.cmd)
            DC_APPLY:
                case (in_data.op)
                    OP_START:
                    begin
                        pstart_next = 1'b1;
                        if (!sending_reg)
                        begin
                            sending_next = 1'b1;
                            rtick_next   = 1'b1;
                        end
                        started_next = 1'b1;
                    end
                    OP_STOP:
                    begin
                        if (in_data.flag)
                            sending_next = 1'b0;
                        pstop_next   = 1'b1;
                        started_next = 1'b0;
                    end
                    OP_CONTINUE:
                        if (!started_reg)
                        begin
                            ppos_next     = in_data.flag;
                            held_pos_next = in_data.song_position;
                            pcont_next    = 1'b1;
                            if (!sending_reg)
                            begin
                                sending_next = 1'b1;
                                rtick_next   = 1'b1;
                            end
                            started_next = 1'b1;
                        end
                    OP_TEMPO:
                        if (started_reg)
                        begin
                            nuw_next   = in_data.user_period;
                            nmw_next   = in_data.midi_period;
                            tempo_next = 1'b1;
                        end
                        else
                        begin
                            tempo_next = 1'b0;
                            uw_next    = in_data.user_period;
                            mw_next    = in_data.midi_period;
                        end
                    OP_ARM:
                        target_next = in_data.signal_at;
                    OP_CLK_ON:
                        if (!sending_reg)
                        begin
                            sending_next = 1'b1;
                            rtick_next   = 1'b1;
                        end
                    OP_CLK_OFF:
                        sending_next = 1'b0;
                    OP_SYNC:
                        if (sync_reg != in_data.flag)
                        begin
                            sync_next = in_data.flag;
                            if (in_data.flag)
                                rtick_next = 1'b1;
                        end
                    default:
                        sync_next = sync_reg;
                endcase
            DC_TICK:
            begin
                millis_next    = millis_reg + 32'd1;
                restarted_next = pstart_reg || pcont_reg || rtick_reg;
                rtick_next     = 1'b0;
            end
            DC_EMIT_START:
            begin
                pstart_next = 1'b0;
                emit_en     = 1'b1;
                emit_kind   = KIND_START;
            end
            DC_EMIT_CLOCK:
                emit_en = 1'b1;
            DC_EMIT_STOP:
            begin
                pstop_next = 1'b0;
                emit_en    = 1'b1;
                emit_kind  = KIND_STOP;
            end
            DC_EMIT_POS:
            begin
                ppos_next = 1'b0;
                emit_en   = ppos_reg && sync_reg;
                emit_kind = KIND_POSITION;
                emit_pos  = held_pos_reg;
            end
            DC_EMIT_CONT:
            begin
                pcont_next = 1'b0;
                emit_en    = 1'b1;
                emit_kind  = KIND_CONTINUE;
            end
            DC_MIDI_ADD:
            begin
                mhit_next = 1'b0;
                if (restarted_reg)
                begin
                    macc_next = '0;
                    mcnt_next = '0;
                    do_apply  = 1'b1;
                end
                else if (mw_reg != '0)
                begin
                    macc_next = madd;
                    mhit_next = madd >= mw_reg;
                end
            end
            DC_MIDI_HIT:
            begin
                if (sending_reg)
                begin
                    emit_en   = 1'b1;
                    mcnt_next = mcnt_reg + 32'd1;
                end
                macc_next = macc_reg - mw_reg;
                cut_next  = '0;
            end
            DC_CUT_MIDI:
                if (cut_reg != CUT_MAX)
                begin
                    macc_next = macc_reg - mw_reg;
                    cut_next  = cut_reg + 1'b1;
                end
                else
                    macc_next = '0;
            DC_MIDI_DONE:
                do_apply = 1'b1;
            DC_USER_ADD:
            begin
                uhit_next = 1'b0;
                if (uw_reg != '0)
                begin
                    uacc_next = uadd;
                    uhit_next = uadd >= uw_reg;
                end
            end
            DC_USER_HIT:
            begin
                ccnt_next = ccnt_reg + 31'd1;
                if (phase_inc >= cpb_reg)
                begin
                    beat_next  = beat_reg + 31'd1;
                    phase_next = '0;
                end
                else
                    phase_next = phase_inc;
                uacc_next = uacc_reg - uw_reg;
                cut_next  = '0;
            end
            DC_CUT_USER:
                if (cut_reg != CUT_MAX)
                begin
                    uacc_next = uacc_reg - uw_reg;
                    cut_next  = cut_reg + 1'b1;
                end
                else
                    uacc_next = '0;
            DC_SIGNAL:
                if (target_reg != '0 && ccnt_reg >= target_reg)
                begin
                    emit_late   = ccnt_reg > target_reg;
                    if (emit_late)
                        late_cnt_next = late_cnt_reg + 16'd1;
                    target_next = '0;
                    emit_en     = 1'b1;
                    emit_kind   = KIND_SIGNAL;
                    emit_port   = 1'b0;
                end
            default:
                do_apply = 1'b0;
        endcase

        if (do_apply && tempo_reg)
        begin
            uw_next    = nuw_reg;
            mw_next    = nmw_reg;
            tempo_next = 1'b0;
        end
    end

    // hold one result back so the final one can carry last
    always_comb
    begin
        stg_next       = stg_reg;
        stg_valid_next = stg_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit_en)
        begin
            if (stg_valid_reg)
            begin
                out_next       = stg_reg;
                out_valid_next = 1'b1;
            end
            stg_next.kind       = emit_kind;
            stg_next.to_port    = emit_port;
            stg_next.position   = emit_pos;
            stg_next.user_clock = ccnt_reg;
            stg_next.beat       = beat_reg;
            stg_next.late       = emit_late;
            stg_next.last       = 1'b0;
            stg_valid_next      = 1'b1;
        end
        else if (ctl.flush && stg_valid_reg)
        begin
            out_next       = stg_reg;
            out_next.last  = 1'b1;
            out_valid_next = 1'b1;
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstart_reg <= 1'b0;  pstop_reg <= 1'b0;
            pcont_reg <= 1'b0;   ppos_reg <= 1'b0;
            held_pos_reg <= '0;
            rtick_reg <= 1'b0;   sending_reg <= 1'b0;
            started_reg <= 1'b0; sync_reg <= 1'b0;
            macc_reg <= '0;      uacc_reg <= '0;
            mw_reg <= '0;        uw_reg <= '0;
            nmw_reg <= '0;       nuw_reg <= '0;
            tempo_reg <= 1'b0;
            mcnt_reg <= '0;      millis_reg <= '0;
            ccnt_reg <= '0;      beat_reg <= '0;
            phase_reg <= '0;     target_reg <= '0;
            late_cnt_reg <= '0;
            restarted_reg <= 1'b0;
            mhit_reg <= 1'b0;    uhit_reg <= 1'b0;
            cut_reg <= '0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cpb_reg <= 10'd96;   tick_en_reg <= 1'b1;
        end
        else
        begin
            pstart_reg <= pstart_next;   pstop_reg <= pstop_next;
            pcont_reg <= pcont_next;     ppos_reg <= ppos_next;
            held_pos_reg <= held_pos_next;
            rtick_reg <= rtick_next;     sending_reg <= sending_next;
            started_reg <= started_next; sync_reg <= sync_next;
            macc_reg <= macc_next;       uacc_reg <= uacc_next;
            mw_reg <= mw_next;           uw_reg <= uw_next;
            nmw_reg <= nmw_next;         nuw_reg <= nuw_next;
            tempo_reg <= tempo_next;
            mcnt_reg <= mcnt_next;       millis_reg <= millis_next;
            ccnt_reg <= ccnt_next;       beat_reg <= beat_next;
            phase_reg <= phase_next;     target_reg <= target_next;
            late_cnt_reg <= late_cnt_next;
            restarted_reg <= restarted_next;
            mhit_reg <= mhit_next;       uhit_reg <= uhit_next;
            cut_reg <= cut_next;
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
            cpb_reg <= cpb_next;         tick_en_reg <= tick_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_reg <= stg_next;
        out_reg <= out_next;
    end

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.flush |=> !stg_valid_reg)
        else $error("staged result survived flush");

    a_cut_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cut_reg <= CUT_MAX)
        else $error("correction count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && stg_valid_reg) |-> out_free)
        else $error("result pushed into a busy output register");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.flush && stg_valid_reg) |=> (out_valid_reg && out_reg.last))
        else $error("final result not marked last");

endmodule

`default_nettype wire

// ----- hdl/midi_clock_generator.sv -----
// MIDI clock generator, one tick request per millisecond.
// Input channel: in_valid / in_stall with in_data (op and its operands).
// Output channel: out_valid / out_stall with out_data. A tick gives zero to
// eight results and the final one carries last; other requests give none.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// clocks_per_beat (0) or tick_enable (1); write only while idle.
// Non-tick requests and disabled ticks give no result.
// An enabled tick emits, in order, start and a clock for a pending start,
// stop for a pending stop, position (sync on), continue and a clock for
// a pending continue, the MIDI clock when its accumulator is reached and
// clocks are sent, and a signal once the user clock meets the armed count;
// each accumulator makes up to MAX_CORRECTIONS overshoot corrections.
// The block works on one request at a time; in_stall is high while a tick
// is in progress. A stalled receiver holds the output register and, once
// the one-deep staging register is also full, the sequencer waits.
// Reset clears all state: clocks idle, not started, sync off,
// clocks_per_beat 96, tick_enable 1.
`default_nettype none

module midi_clock_generator
    import mcg_pkg::*;
#(
    parameter int MAX_CORRECTIONS = 100
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_t        in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_t            out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [9:0] cfg_data
);

    ctrl_t   ctl;
    status_t st;

    assign cfg_ready = 1'b1;

    mcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_tick  (in_data.op == OP_TICK),
        .st       (st),
        .in_stall (in_stall),
        .ctl      (ctl)
    );

    mcg_dp #(
        .MAX_CORRECTIONS (MAX_CORRECTIONS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .st        (st)
    );

endmodule

`default_nettype wire
